[hdl/csrp_pkg.sv]
// Package for the card sequence recorder and player.
// Holds beat and configuration types, mode, status and action codes, and table lookups.
// No dependencies.
`timescale 1ns / 1ps

package csrp_pkg;

   localparam int SEQ_DEPTH   = 16;
   localparam int COLOR_CODES = 16;
   localparam int IDX_W       = $clog2(SEQ_DEPTH);
   localparam int CNT_W       = 5;
   localparam int OP_W        = 3;

   localparam logic [2:0] ACT_TRIGGER  = 3'd0;
   localparam logic [2:0] ACT_COLOR    = 3'd1;
   localparam logic [2:0] ACT_QUERY    = 3'd2;
   localparam logic [2:0] ACT_STARTED  = 3'd3;
   localparam logic [2:0] ACT_FINISHED = 3'd4;
   localparam logic [2:0] ACT_TICK     = 3'd5;

   localparam logic [1:0] MODE_IDLE  = 2'd0;
   localparam logic [1:0] MODE_PROG  = 2'd1;
   localparam logic [1:0] MODE_READY = 2'd2;
   localparam logic [1:0] MODE_RUN   = 2'd3;

   localparam logic [3:0] STAT_IGNORED  = 4'd0;
   localparam logic [3:0] STAT_ENTERED  = 4'd1;
   localparam logic [3:0] STAT_RUNSTART = 4'd2;
   localparam logic [3:0] STAT_PUSHED   = 4'd3;
   localparam logic [3:0] STAT_FULL     = 4'd4;
   localparam logic [3:0] STAT_FINISHED = 4'd5;
   localparam logic [3:0] STAT_EMPTY    = 4'd6;
   localparam logic [3:0] STAT_BUSY     = 4'd7;
   localparam logic [3:0] STAT_GAP      = 4'd8;

   localparam logic [2:0] REG_TRIG_LEFT  = 3'd0;
   localparam logic [2:0] REG_TRIG_RIGHT = 3'd1;
   localparam logic [2:0] REG_INPUT_MAP  = 3'd2;
   localparam logic [2:0] REG_PLAN_MAP   = 3'd3;
   localparam logic [2:0] REG_GAP_TICKS  = 3'd4;

   localparam logic [7:0]  RST_TRIG_LEFT  = 8'd9;
   localparam logic [7:0]  RST_TRIG_RIGHT = 8'd10;
   localparam logic [47:0] RST_INPUT_MAP  = 48'd17024;
   localparam logic [15:0] RST_PLAN_MAP   = 16'd17185;
   localparam logic [15:0] RST_GAP_TICKS  = 16'd1000;

   typedef struct packed {
      logic [2:0] action;
      logic [7:0] left_color;
      logic [7:0] right_color;
      logic [7:0] seen_color;
   } req_type;

   typedef struct packed {
      logic       plan_valid;
      logic [3:0] plan_color;
      logic       run_start_pulse;
      logic [1:0] mode;
      logic [4:0] stored_count;
      logic [3:0] event_status;
   } rsp_type;

   typedef struct packed {
      logic [7:0]  trigger_left_color;
      logic [7:0]  trigger_right_color;
      logic [47:0] input_map;
      logic [15:0] plan_map;
      logic [15:0] gap_ticks;
   } cfg_type;

   typedef struct packed {
      logic            en;
      logic [IDX_W-1:0] addr;
      logic [OP_W-1:0]  data;
   } store_wr_type;

   function automatic logic [OP_W-1:0] op_of(input logic [47:0] map, input logic [3:0] code);
      logic [5:0] base;
      base = {2'b00, code} * 6'd3;
      return map[base +: 3];
   endfunction

   function automatic logic [3:0] plan_of(input logic [15:0] map, input logic [OP_W-1:0] op);
      logic [1:0] idx;
      idx = op[1:0] - 2'd1;
      return map[{idx, 2'b00} +: 4];
   endfunction

endpackage

[hdl/csrp_csr.sv]
// Configuration registers of the card sequence recorder and player.
// Depends on csrp_pkg for the configuration type, register indexes and reset values.
`timescale 1ns / 1ps

module csrp_csr
   import csrp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [47:0] csr_wdata,
   output cfg_type     cfg
);

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            REG_TRIG_LEFT:  cfg_in.trigger_left_color  = csr_wdata[7:0];
            REG_TRIG_RIGHT: cfg_in.trigger_right_color = csr_wdata[7:0];
            REG_INPUT_MAP:  cfg_in.input_map           = csr_wdata;
            REG_PLAN_MAP:   cfg_in.plan_map            = csr_wdata[15:0];
            REG_GAP_TICKS:  cfg_in.gap_ticks           = csr_wdata[15:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.trigger_left_color  <= RST_TRIG_LEFT;
         cfg_ff.trigger_right_color <= RST_TRIG_RIGHT;
         cfg_ff.input_map           <= RST_INPUT_MAP;
         cfg_ff.plan_map            <= RST_PLAN_MAP;
         cfg_ff.gap_ticks           <= RST_GAP_TICKS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[hdl/csrp_store.sv]
// Operation store: one write port and one registered read port.
// Depends on csrp_pkg for the depth, widths and write port type.
`timescale 1ns / 1ps

module csrp_store
   import csrp_pkg::*;
(
   input  logic             clock,
   input  store_wr_type     wr,
   input  logic [IDX_W-1:0] rd_addr,
   output logic [OP_W-1:0]  rd_data
);

   logic [OP_W-1:0] mem_ff [SEQ_DEPTH];
   logic [OP_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.addr] <= wr.data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/csrp_ctrl.sv]
// Mode machine and event sequencer with the result register.
// Depends on csrp_pkg; drives the operation store and reads the configuration.
`timescale 1ns / 1ps

module csrp_ctrl
   import csrp_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  cfg_type          cfg,
   input  logic             req_valid,
   output logic             req_ready,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsp_type          rsp_data,
   output store_wr_type     st_wr,
   output logic [IDX_W-1:0] st_rd_addr,
   input  logic [OP_W-1:0]  st_rd_data
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_EXEC = 4'b0010,
      ST_SCAN = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

   state_type        state_ff, state_in;
   req_type          req_ff, req_in;
   logic [1:0]       mode_ff, mode_in;
   logic [CNT_W-1:0] op_count_ff, op_count_in;
   logic [CNT_W-1:0] run_index_ff, run_index_in;
   logic             plan_pending_ff, plan_pending_in;
   logic [3:0]       pending_color_ff, pending_color_in;
   logic             gap_active_ff, gap_active_in;
   logic [15:0]      gap_left_ff, gap_left_in;
   logic             res_valid_ff, res_valid_in;
   logic [3:0]       res_color_ff, res_color_in;
   logic             res_pulse_ff, res_pulse_in;
   logic [3:0]       res_status_ff, res_status_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;
   logic             do_clear;
   logic [OP_W-1:0]  seen_op;
   logic [CNT_W-1:0] next_index;

   assign seen_op    = op_of(cfg.input_map, req_ff.seen_color[3:0]);
   assign next_index = run_index_ff + CNT_W'(1);

   always_comb begin
      state_in         = state_ff;
      req_in           = req_ff;
      mode_in          = mode_ff;
      op_count_in      = op_count_ff;
      run_index_in     = run_index_ff;
      plan_pending_in  = plan_pending_ff;
      pending_color_in = pending_color_ff;
      gap_active_in    = gap_active_ff;
      gap_left_in      = gap_left_ff;
      res_valid_in     = res_valid_ff;
      res_color_in     = res_color_ff;
      res_pulse_in     = res_pulse_ff;
      res_status_in    = res_status_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      rsp_in           = rsp_ff;
      req_ready        = 1'b0;
      do_clear         = 1'b0;
      st_wr.en         = 1'b0;
      st_wr.addr       = op_count_ff[IDX_W-1:0];
      st_wr.data       = seen_op;
      st_rd_addr       = run_index_ff[IDX_W-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               req_in   = req_data;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            res_valid_in  = 1'b0;
            res_color_in  = 4'd0;
            res_pulse_in  = 1'b0;
            res_status_in = STAT_IGNORED;
            state_in      = ST_DONE;
            case (req_ff.action)
               ACT_TRIGGER: begin
                  if (req_ff.left_color == cfg.trigger_left_color &&
                      req_ff.right_color == cfg.trigger_right_color) begin
                     if (mode_ff == MODE_IDLE) begin
                        mode_in       = MODE_PROG;
                        op_count_in   = '0;
                        run_index_in  = '0;
                        res_status_in = STAT_ENTERED;
                     end else if (mode_ff == MODE_RUN) begin
                        res_status_in = STAT_BUSY;
                     end else if (op_count_ff == '0) begin
                        res_status_in = STAT_EMPTY;
                     end else begin
                        mode_in         = MODE_RUN;
                        run_index_in    = '0;
                        plan_pending_in = 1'b0;
                        res_pulse_in    = 1'b1;
                        res_status_in   = STAT_RUNSTART;
                     end
                  end
               end
               ACT_COLOR: begin
                  if (mode_ff == MODE_PROG && req_ff.seen_color < 8'(COLOR_CODES) &&
                      seen_op != '0) begin
                     if (op_count_ff >= CNT_W'(SEQ_DEPTH)) begin
                        mode_in       = MODE_READY;
                        res_status_in = STAT_FULL;
                     end else begin
                        st_wr.en      = 1'b1;
                        op_count_in   = op_count_ff + CNT_W'(1);
                        if (op_count_ff + CNT_W'(1) >= CNT_W'(SEQ_DEPTH)) begin
                           mode_in = MODE_READY;
                        end
                        res_status_in = STAT_PUSHED;
                     end
                  end
               end
               ACT_QUERY: begin
                  if (mode_ff == MODE_RUN) begin
                     if (gap_active_ff && gap_left_ff != '0) begin
                        res_status_in = STAT_GAP;
                     end else begin
                        gap_active_in = 1'b0;
                        if (plan_pending_ff) begin
                           res_valid_in = 1'b1;
                           res_color_in = pending_color_ff;
                        end else if (run_index_ff < op_count_ff) begin
                           state_in = ST_SCAN;
                        end else begin
                           do_clear      = 1'b1;
                           res_status_in = STAT_FINISHED;
                        end
                     end
                  end
               end
               ACT_STARTED: begin
                  if (mode_ff == MODE_RUN && plan_pending_ff) begin
                     plan_pending_in = 1'b0;
                     run_index_in    = next_index;
                  end
               end
               ACT_FINISHED: begin
                  if (mode_ff == MODE_RUN) begin
                     if (run_index_ff < op_count_ff) begin
                        gap_active_in = 1'b1;
                        gap_left_in   = cfg.gap_ticks;
                        res_status_in = STAT_GAP;
                     end else begin
                        do_clear      = 1'b1;
                        res_status_in = STAT_FINISHED;
                     end
                  end
               end
               ACT_TICK: begin
                  if (gap_active_ff && gap_left_ff != '0) begin
                     gap_left_in = gap_left_ff - 16'd1;
                  end
               end
               default: begin
                  res_status_in = STAT_IGNORED;
               end
            endcase
         end
         ST_SCAN: begin
            if (st_rd_data >= 3'd1 && st_rd_data <= 3'd4) begin
               pending_color_in = plan_of(cfg.plan_map, st_rd_data);
               plan_pending_in  = 1'b1;
               res_valid_in     = 1'b1;
               res_color_in     = plan_of(cfg.plan_map, st_rd_data);
               state_in         = ST_DONE;
            end else begin
               run_index_in = next_index;
               st_rd_addr   = next_index[IDX_W-1:0];
               if (next_index >= op_count_ff) begin
                  do_clear      = 1'b1;
                  res_status_in = STAT_FINISHED;
                  state_in      = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in.plan_valid      = res_valid_ff;
               rsp_in.plan_color      = res_color_ff;
               rsp_in.run_start_pulse = res_pulse_ff;
               rsp_in.mode            = mode_ff;
               rsp_in.stored_count    = op_count_ff;
               rsp_in.event_status    = res_status_ff;
               rsp_valid_in           = 1'b1;
               state_in               = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (do_clear) begin
         op_count_in      = '0;
         run_index_in     = '0;
         mode_in          = MODE_IDLE;
         plan_pending_in  = 1'b0;
         pending_color_in = 4'd0;
         gap_active_in    = 1'b0;
         gap_left_in      = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         mode_ff          <= MODE_IDLE;
         op_count_ff      <= '0;
         run_index_ff     <= '0;
         plan_pending_ff  <= 1'b0;
         pending_color_ff <= 4'd0;
         gap_active_ff    <= 1'b0;
         gap_left_ff      <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         mode_ff          <= mode_in;
         op_count_ff      <= op_count_in;
         run_index_ff     <= run_index_in;
         plan_pending_ff  <= plan_pending_in;
         pending_color_ff <= pending_color_in;
         gap_active_ff    <= gap_active_in;
         gap_left_ff      <= gap_left_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff        <= req_in;
      res_valid_ff  <= res_valid_in;
      res_color_ff  <= res_color_in;
      res_pulse_ff  <= res_pulse_in;
      res_status_ff <= res_status_in;
      rsp_ff        <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

[hdl/card_sequence_recorder_player.sv]
// Card sequence recorder and player. A beat is accepted in the idle state, then passes
// the execute and done states; a plan query can walk up to 16 stored operations in the scan
// state between them. The done state loads the output register once the prior result is
// taken; the single read port of the operation store sets the pace of the walk.
// Synchronous active-high reset restores idle mode and the default configuration.
`timescale 1ns / 1ps

module card_sequence_recorder_player
   import csrp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [47:0] csr_wdata
);

   cfg_type          cfg;
   store_wr_type     st_wr;
   logic [IDX_W-1:0] st_rd_addr;
   logic [OP_W-1:0]  st_rd_data;

   csrp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   csrp_store u_store (
      .clock   (clock),
      .wr      (st_wr),
      .rd_addr (st_rd_addr),
      .rd_data (st_rd_data)
   );

   csrp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .st_wr      (st_wr),
      .st_rd_addr (st_rd_addr),
      .st_rd_data (st_rd_data)
   );

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.stored_count <= 5'(SEQ_DEPTH))
      else $error("stored count beyond the store depth");

   a_start_pulse: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.run_start_pulse) |->
         (rsp_data.mode == MODE_RUN && rsp_data.event_status == STAT_RUNSTART))
      else $error("run start pulse without a run start");

   a_plan_in_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.plan_valid) |->
         (rsp_data.mode == MODE_RUN && rsp_data.event_status == STAT_IGNORED))
      else $error("plan handed out outside a run");

   a_finish_clears: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.event_status == STAT_FINISHED) |->
         (rsp_data.mode == MODE_IDLE && rsp_data.stored_count == 5'd0))
      else $error("finished run left state behind");

   a_store_write: assert property (@(posedge clock) disable iff (reset)
      st_wr.en |-> !req_ready)
      else $error("store written while waiting for a beat");

endmodule
